// ----- rtl/core/i2cee_pkg.sv -----
// ============================================================================
// i2cee_pkg
// Shared types and constants for the I2C serial EEPROM slave.
// ============================================================================
package i2cee_pkg;

   localparam int WA_W   = 13;   // word address width (size_mask width)
   localparam int PM_W   = 6;    // page mask width
   localparam int CSR_IW = 2;    // register index width
   localparam int CSR_DW = 13;   // register data width

   localparam logic [3:0] DEV_CODE = 4'hA;   // device type nibble
   localparam logic [7:0] ERASED   = 8'hFF;  // blank byte value

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_CHIP_MODE   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_SIZE_MASK   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_PAGE_MASK   = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_DEVICE_SEL  = 2'd3;

   // chip modes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_WORD7 = 2'd1;
   localparam logic [1:0] MODE_DEVHI = 2'd2;
   localparam logic [1:0] MODE_ADDR2 = 2'd3;

   typedef enum logic [2:0] {
      PH_STANDBY   = 3'd0,
      PH_WORD7     = 3'd1,
      PH_WRITE     = 3'd2,
      PH_DEVICE    = 3'd3,
      PH_ADDR_LOW  = 3'd4,
      PH_ADDR_HIGH = 3'd5,
      PH_READ      = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      S_CLEAR = 3'd0,
      S_IDLE  = 3'd1,
      S_RD    = 3'd2,
      S_RDW   = 3'd3,
      S_CP    = 3'd4,
      S_CPD   = 3'd5,
      S_CM    = 3'd6,
      S_CMD   = 3'd7
   } seq_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_READ   = 2'd1,
      ACT_COPY   = 2'd2,
      ACT_COMMIT = 2'd3
   } act_type;

endpackage

// ----- rtl/core/i2cee_ram.sv -----
// ============================================================================
// i2cee_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
module i2cee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/i2c_serial_eeprom_slave_top.sv -----
// ============================================================================
// i2c_serial_eeprom_slave_top
// Bit-level I2C serial EEPROM slave with page cache and byte memory.
// ============================================================================
// A line sample that needs no memory work has its result registered in the
//   cycle after acceptance; a read fetch (read start or master ACK) passes
//   S_RD and S_RDW; a write start (page load) or a STOP after a write (page
//   commit) walks S_CP/S_CPD or S_CM/S_CMD. One item is in flight at a time.
// Reset: synchronous; after reset a clearing pass writes 0xFF to every memory
//   byte before the first item is taken.
// MEM_DEPTH and PAGE_DEPTH must be powers of two; the block does not check it.
module i2c_serial_eeprom_slave_top
   import i2cee_pkg::*;
#(
   parameter int MEM_DEPTH  = 8192,
   parameter int PAGE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   // line samples
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_scl_level,
   input  logic              req_sda_level,
   // results
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_sda_read,
   output logic              rsp_dirty,
   // registers
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int PW = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
   localparam logic [PW-1:0] PG_MASK = PW'(PAGE_DEPTH - 1);

   // memory index: address taken modulo MEM_DEPTH
   function automatic logic [AW-1:0] mem_index(input logic [WA_W-1:0] a);
      logic [15:0] a16;
      a16 = {3'b000, a};
      return a16[AW-1:0];
   endfunction

   // page buffer index: modulo PAGE_DEPTH
   function automatic logic [PW-1:0] pg_index(input logic [7:0] i);
      return i[PW-1:0] & PG_MASK;
   endfunction

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [1:0]      mode_ff;
   logic [WA_W-1:0] size_ff;
   logic [PM_W-1:0] pmask_ff;
   logic [2:0]      dsel_ff;

   seq_type         state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic [WA_W-1:0] wa_ff, wa_in;
   logic [3:0]      bc_ff, bc_in;
   logic [7:0]      sb_ff, sb_in;
   logic            so_ff, so_in;
   logic            sd_ff, sd_in;
   logic            pclk_ff, pdat_ff;
   logic            changed_ff, changed_in;
   logic [PM_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]   clr_ff;
   logic            pend_ff;
   logic [PM_W-1:0] pidx_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_sda_ff, rsp_dirty_ff;

   // step outputs
   act_type         act;
   logic            pg_byte_we;
   logic [PW-1:0]   pg_byte_idx;
   logic            acc, emit;

   // ram ports
   logic            mem_we, pg_we;
   logic [AW-1:0]   mem_wa, mem_ra;
   logic [7:0]      mem_wd, mem_rd;
   logic [PW-1:0]   pg_wa, pg_ra;
   logic [7:0]      pg_wd, pg_rd;

   logic [WA_W-1:0] pmask13, page_base;

   assign pmask13   = {{(WA_W-PM_W){1'b0}}, pmask_ff};
   assign page_base = wa_ff & ~pmask13;

   assign csr_ready = 1'b1;
   assign req_stall = !(state_ff == S_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign acc       = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // line step: bus protocol state for one sample
   // ---------------------------------------------------------------------
   always_comb begin
      logic            rise, fall, line;
      logic [7:0]      b;
      logic [2:0]      dev;
      logic [WA_W-1:0] wa_p1;
      rise  = !pclk_ff && req_scl_level;
      fall  = pclk_ff && !req_scl_level;
      line  = req_sda_level & sd_ff;
      b     = sb_ff;
      dev   = b[3:1];
      wa_p1 = wa_ff + WA_W'(1);

      phase_in    = phase_ff;
      wa_in       = wa_ff;
      bc_in       = bc_ff;
      sb_in       = sb_ff;
      so_in       = so_ff;
      sd_in       = sd_ff;
      act         = ACT_NONE;
      pg_byte_we  = 1'b0;
      pg_byte_idx = pg_index({2'b00, wa_ff[PM_W-1:0] & pmask_ff});

      if (mode_ff == MODE_NONE) begin
         // no chip on the bus
      end else if (pclk_ff && req_scl_level && !pdat_ff && req_sda_level) begin
         // STOP
         if (phase_ff == PH_WRITE) act = ACT_COMMIT;
         sd_in = 1'b1; bc_in = '0; sb_in = '0; so_in = 1'b0; phase_in = PH_STANDBY;
      end else if (pclk_ff && req_scl_level && pdat_ff && !req_sda_level) begin
         // START
         bc_in = '0; sd_in = 1'b1; sb_in = '0; so_in = 1'b0;
         phase_in = (mode_ff == MODE_WORD7) ? PH_WORD7 : PH_DEVICE;
      end else if (phase_ff != PH_STANDBY) begin
         if (!so_ff) begin
            if (rise) begin
               if (bc_ff >= 4'd8) begin
                  bc_in = bc_ff + 4'd1;
                  // byte complete
                  case (phase_ff)
                     PH_WORD7: begin
                        wa_in = {{(WA_W-7){1'b0}}, b[7:1]};
                        bc_in = '0;
                        if (b[0]) begin
                           so_in = 1'b1; phase_in = PH_READ; act = ACT_READ;
                        end else begin
                           sb_in = '0; so_in = 1'b0; phase_in = PH_WRITE; act = ACT_COPY;
                        end
                     end
                     PH_WRITE: begin
                        pg_byte_we = 1'b1;
                        wa_in = (wa_ff & ~pmask13) | (wa_p1 & pmask13);
                        sb_in = '0;
                     end
                     PH_DEVICE: begin
                        if (mode_ff == MODE_DEVHI) dev = dev & ~size_ff[10:8];
                        if (b[7:4] != DEV_CODE || dev != dsel_ff) begin
                           sd_in = 1'b1; bc_in = '0; sb_in = '0; so_in = 1'b0;
                           phase_in = PH_STANDBY;
                        end else begin
                           bc_in = '0;
                           if (mode_ff == MODE_DEVHI)
                              wa_in = {2'b00, b[3:1], wa_ff[7:0]} & size_ff;
                           if (b[0]) begin
                              so_in = 1'b1; phase_in = PH_READ; act = ACT_READ;
                           end else begin
                              sb_in = '0; so_in = 1'b0;
                              phase_in = (mode_ff == MODE_DEVHI) ? PH_ADDR_LOW
                                                                 : PH_ADDR_HIGH;
                           end
                        end
                     end
                     PH_ADDR_LOW: begin
                        wa_in = {wa_ff[WA_W-1:8], b} & size_ff;
                        bc_in = '0; sb_in = '0; so_in = 1'b0;
                        phase_in = PH_WRITE; act = ACT_COPY;
                     end
                     PH_ADDR_HIGH: begin
                        wa_in = {b[4:0], wa_ff[7:0]} & size_ff;
                        bc_in = '0; sb_in = '0; so_in = 1'b0;
                        phase_in = PH_ADDR_LOW;
                     end
                     default: begin
                        sd_in = 1'b1; bc_in = '0; sb_in = '0; so_in = 1'b0;
                        phase_in = PH_STANDBY;
                     end
                  endcase
               end else begin
                  sb_in = {sb_ff[6:0], line};
                  bc_in = bc_ff + 4'd1;
               end
            end else if (fall) begin
               sd_in = 1'b1;
               if (bc_ff == 4'd8) sd_in = 1'b0;
               else if (bc_ff >= 4'd9) bc_in = '0;
            end
         end else begin
            if (rise) begin
               if (bc_ff >= 4'd9 && !line) begin
                  if (phase_ff == PH_READ) begin
                     wa_in = wa_p1 & size_ff;
                     bc_in = '0;
                     act   = ACT_READ;
                  end else begin
                     sd_in = 1'b1; bc_in = '0; sb_in = '0; so_in = 1'b0;
                     phase_in = PH_STANDBY;
                  end
               end
            end else if (fall) begin
               if (bc_ff < 4'd8) begin
                  sd_in = sb_ff[7];
                  sb_in = {sb_ff[6:0], 1'b0};
                  bc_in = bc_ff + 4'd1;
               end else if (bc_ff == 4'd8) begin
                  sd_in = 1'b1;
                  bc_in = bc_ff + 4'd1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequencer next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == AW'(MEM_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (acc) begin
               case (act)
                  ACT_READ:   state_in = S_RD;
                  ACT_COPY:   state_in = S_CP;
                  ACT_COMMIT: state_in = S_CM;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_RD:    state_in = S_RDW;
         S_CP:    if (cnt_ff == pmask_ff) state_in = S_CPD;
         S_CM:    if (cnt_ff == pmask_ff) state_in = S_CMD;
         S_RDW, S_CPD, S_CMD: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // memory controls, page walk and result
   // ---------------------------------------------------------------------
   always_comb begin
      logic [WA_W-1:0] pend_addr;
      pend_addr  = page_base | {{(WA_W-PM_W){1'b0}}, pidx_ff};

      mem_we     = 1'b0;
      mem_wa     = mem_index(pend_addr);
      mem_wd     = pg_rd;
      mem_ra     = mem_index(page_base | {{(WA_W-PM_W){1'b0}}, cnt_ff});
      pg_we      = 1'b0;
      pg_wa      = pg_index({2'b00, pidx_ff});
      pg_wd      = mem_rd;
      pg_ra      = pg_index({2'b00, cnt_ff});
      changed_in = changed_ff;
      cnt_in     = cnt_ff;
      emit       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = ERASED;
            pg_we  = 1'b1;
            pg_wa  = pg_index(8'({16'h0000, clr_ff} & 16'h00FF));
            pg_wd  = ERASED;
         end
         S_IDLE: begin
            cnt_in = '0;
            if (acc) begin
               pg_we = pg_byte_we;
               pg_wa = pg_byte_idx;
               pg_wd = sb_ff;
               emit  = (act == ACT_NONE);
            end
         end
         S_RD: begin
            mem_ra = mem_index(wa_ff);
         end
         S_RDW: begin
            emit = 1'b1;
         end
         S_CP, S_CPD: begin
            pg_we  = pend_ff;
            cnt_in = cnt_ff + PM_W'(1);
            emit   = (state_ff == S_CPD);
         end
         S_CM, S_CMD: begin
            if (pend_ff && mem_rd != pg_rd) begin
               mem_we     = 1'b1;
               changed_in = 1'b1;
            end
            cnt_in = cnt_ff + PM_W'(1);
            emit   = (state_ff == S_CMD);
         end
         default: ;
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   i2cee_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   i2cee_ram #(.WIDTH(8), .DEPTH(PAGE_DEPTH)) u_page (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_wa),
      .wr_data (pg_wd),
      .rd_addr (pg_ra),
      .rd_data (pg_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         size_ff      <= WA_W'(127);
         pmask_ff     <= PM_W'(3);
         dsel_ff      <= '0;
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_STANDBY;
         wa_ff        <= '0;
         bc_ff        <= '0;
         sb_ff        <= '0;
         so_ff        <= 1'b0;
         sd_ff        <= 1'b1;
         pclk_ff      <= 1'b1;
         pdat_ff      <= 1'b1;
         changed_ff   <= 1'b0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CHIP_MODE:  mode_ff  <= csr_wdata[1:0];
               CSR_SIZE_MASK:  size_ff  <= csr_wdata;
               CSR_PAGE_MASK:  pmask_ff <= csr_wdata[PM_W-1:0];
               CSR_DEVICE_SEL: dsel_ff  <= csr_wdata[2:0];
               default: ;
            endcase
         end
         state_ff     <= state_in;
         changed_ff   <= changed_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_ff + AW'(1);
         pend_ff      <= (state_ff == S_CP) || (state_ff == S_CM);
         rsp_valid_ff <= rsp_valid_in;
         if (acc) begin
            phase_ff <= phase_in;
            wa_ff    <= wa_in;
            bc_ff    <= bc_in;
            sb_ff    <= sb_in;
            so_ff    <= so_in;
            sd_ff    <= sd_in;
            pclk_ff  <= req_scl_level;
            pdat_ff  <= req_sda_level;
         end else if (state_ff == S_RDW) begin
            sb_ff <= mem_rd;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      pidx_ff <= cnt_ff;
      if (acc) rsp_sda_ff <= req_sda_level & sd_in;
      if (emit) rsp_dirty_ff <= changed_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sda_read = rsp_sda_ff;
   assign rsp_dirty    = rsp_dirty_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_mem_we_ctx: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_CM || state_ff == S_CMD))
      else $error("memory written outside clear or commit");

   a_dirty_sticky: assert property (@(posedge clock) disable iff (reset)
      changed_ff |=> changed_ff)
      else $error("dirty flag dropped");

   a_rd_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |=> state_ff == S_RDW)
      else $error("read fetch sequence broken");

   a_bc_range: assert property (@(posedge clock) disable iff (reset)
      bc_ff <= 4'd9)
      else $error("bit counter out of range");

endmodule
